/* src/ebd_pkg.sv */
// Shared types and byte codes for the escaped byte deframer.
package ebd_pkg;

  localparam logic [7:0] CodeStart  = 8'h54;
  localparam logic [7:0] CodeEnd    = 8'h55;
  localparam logic [7:0] CodeEscape = 8'h56;
  localparam logic [7:0] CodeAck    = 8'h57;
  localparam logic [7:0] CodeNack   = 8'h58;
  localparam logic [7:0] CodePing   = 8'h59;

  localparam int unsigned LenW = 9;

  typedef enum logic [2:0] {
    EV_ABSORBED = 3'd0,
    EV_STORED   = 3'd1,
    EV_DROPPED  = 3'd2,
    EV_FRAMEEND = 3'd3,
    EV_ACK      = 3'd4,
    EV_NACK     = 3'd5,
    EV_PING     = 3'd6
  } event_kind_e;

  typedef struct packed {
    event_kind_e       kind;
    logic [7:0]        data_byte;
    logic [7:0]        data_index;
    logic [LenW-1:0]   frame_length;
  } ebd_result_t;

endpackage

/* src/ebd_intf.sv */
// Request channel interfaces for received bytes and decoded events.
interface ebd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ebd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic [8:0] frame_length;

  modport source (output valid, output event_kind, output data_byte, output data_index,
                  output frame_length, input ready);
  modport sink   (input valid, input event_kind, input data_byte, input data_index,
                  input frame_length, output ready);
endinterface

/* src/ebd_core.sv */
// Byte classifier with the escape, in-frame and write position state.
module ebd_core
  import ebd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [LenW-1:0]   limit_i,
  output ebd_result_t       result_o
);

  logic            escape_q, escape_d;
  logic            in_frame_q, in_frame_d;
  logic [LenW-1:0] pos_q, pos_d;

  logic is_event_code;
  logic is_frame_code;
  logic take_data;

  always_comb begin
    is_event_code = (byte_i == CodeAck) || (byte_i == CodeNack) || (byte_i == CodePing);
    is_frame_code = (byte_i == CodeStart) || (byte_i == CodeEnd) || (byte_i == CodeEscape);

    escape_d   = escape_q;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    take_data  = 1'b0;

    result_o              = '0;
    result_o.kind         = EV_ABSORBED;

    if (is_event_code) begin
      if (in_frame_q) begin
        take_data = 1'b1;
      end else if (byte_i == CodeAck) begin
        result_o.kind = EV_ACK;
      end else if (byte_i == CodeNack) begin
        result_o.kind = EV_NACK;
      end else begin
        result_o.kind = EV_PING;
      end
    end else if (is_frame_code) begin
      if (escape_q) begin
        take_data = 1'b1;
      end else if (byte_i == CodeEnd) begin
        in_frame_d            = 1'b0;
        result_o.kind         = EV_FRAMEEND;
        result_o.frame_length = pos_q;
        pos_d                 = '0;
      end else if (byte_i == CodeEscape) begin
        escape_d = 1'b1;
      end else begin
        in_frame_d = 1'b1;
        pos_d      = '0;
      end
    end else begin
      take_data = 1'b1;
    end

    if (take_data) begin
      escape_d = 1'b0;
      if (pos_q < limit_i) begin
        result_o.kind       = EV_STORED;
        result_o.data_byte  = byte_i;
        result_o.data_index = pos_q[7:0];
        pos_d               = pos_q + LenW'(1);
      end else begin
        result_o.kind = EV_DROPPED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q   <= 1'b0;
      in_frame_q <= 1'b0;
      pos_q      <= '0;
    end else if (step_i) begin
      escape_q   <= escape_d;
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
    end
  end

`ifndef SYNTHESIS
  // The position can never pass the hard frame limit.
  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LenW'(256))
    else $error("write position beyond 256");

  // An unescaped END always rewinds the position.
  a_end_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !escape_q && byte_i == CodeEnd) |=> (pos_q == '0 && !in_frame_q))
    else $error("END did not close the frame");

  // A stored byte always lies below the limit in force.
  a_store_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.kind == EV_STORED) |-> ({1'b0, result_o.data_index} < limit_i))
    else $error("stored index at or beyond limit");

  // Control events outside a frame leave the escape flag alone.
  a_event_keeps_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !in_frame_q &&
     (byte_i == CodeAck || byte_i == CodeNack || byte_i == CodePing))
    |=> (escape_q == $past(escape_q)))
    else $error("control event changed the escape flag");
`endif

endmodule

/* src/escaped_byte_deframer.sv */
// An accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset clears the escape flag, the in-frame flag, the write position, both
// valid flags and sets the frame length limit to 256; no clearing pass.
module escaped_byte_deframer
  import ebd_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LenW-1:0]   cfg_wdata_i,
  ebd_in_if.sink            rx_i,
  ebd_out_if.source         ev_o
);

  localparam int unsigned LimitCap = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;

  logic [LenW-1:0] max_len_q;
  logic [LenW-1:0] limit;

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  ebd_result_t     out_q;
  ebd_result_t     result;

  logic out_free;
  logic advance;

  always_comb begin
    limit = (max_len_q > LenW'(LimitCap)) ? LenW'(LimitCap) : max_len_q;
  end

  assign out_free   = !out_valid_q || ev_o.ready;
  assign advance    = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LenW'(256);
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  ebd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .limit_i  (limit),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign ev_o.valid        = out_valid_q;
  assign ev_o.event_kind   = out_q.kind;
  assign ev_o.data_byte    = out_q.data_byte;
  assign ev_o.data_index   = out_q.data_index;
  assign ev_o.frame_length = out_q.frame_length;

`ifndef SYNTHESIS
  // A waiting result is never overwritten by the next byte.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ev_o.ready) |=> (out_valid_q && out_q == $past(out_q)))
    else $error("stalled result changed");

  // A byte in the input register moves on whenever the result side is free.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_free) |=> out_valid_q)
    else $error("byte lost between stages");

  // The limit in force never exceeds the configured cap.
  a_limit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit <= LenW'(LimitCap) && limit <= max_len_q)
    else $error("limit above cap");
`endif

endmodule
